>>> rtl/gcb_pkg.sv
// shared types, constants and elaboration-time functions of the gamma/contrast/brightness block
`default_nettype none

package gcb_pkg;

    // configuration register indexes
    localparam logic [1:0] CFG_CONTRAST   = 2'd0;
    localparam logic [1:0] CFG_GAMMA_EXP  = 2'd1;
    localparam logic [1:0] CFG_BRIGHTNESS = 2'd2;

    localparam int CFG_BITS = 8;

    // exponent log2 distance split as d = 100 * a + b
    localparam int A_BITS   = 29;
    localparam int B_BITS   = 7;
    localparam int E_BITS   = 37;   // Q5.32 exponent magnitude
    localparam int ONE_BITS = 33;   // Q1.32, holds 1.0 exactly
    localparam int T_BITS   = 15;   // b * gamma + 50

    // floor(t / 100) = (t * 5243) >> 19 for t below 43690
    localparam int DIV100_M     = 5243;
    localparam int DIV100_SHIFT = 19;
    localparam int TQ_BITS      = 28;

    // total register stages from input to output
    localparam int PIPE_DEPTH = 43;

    typedef struct packed {
        logic [CFG_BITS-1:0] contrast;
        logic [CFG_BITS-1:0] gamma_exp;
        logic [CFG_BITS-1:0] brightness;
    } t_gcb_cfg;

    typedef struct packed {
        logic [ONE_BITS-1:0] r;
        logic [E_BITS-1:0]   e;
        logic                zero;
    } t_exp_data;

    // log2 of v as unsigned Q.32, each fraction bit by squaring the mantissa
    function automatic logic [63:0] gcb_log2_q32(input logic [63:0] v);
        logic [63:0] n;
        logic [63:0] m;
        logic [63:0] frac;
        int i;
        n = 64'd0;
        for (i = 0; i < 31; i++) begin
            if ((v >> (n + 64'd1)) != 64'd0) begin
                n = n + 64'd1;
            end
        end
        m = v << (64'd31 - n);
        frac = 64'd0;
        for (i = 0; i < 32; i++) begin
            m = (m * m) >> 31;
            frac = frac << 1;
            if (m >= 64'h1_0000_0000) begin
                frac = frac | 64'd1;
                m = m >> 1;
            end
        end
        return (n << 32) | frac;
    endfunction

    function automatic logic [63:0] gcb_isqrt(input logic [63:0] a_in);
        logic [63:0] a;
        logic [63:0] r;
        logic [63:0] bit_v;
        int i;
        a = a_in;
        r = 64'd0;
        bit_v = 64'd1 << 62;
        for (i = 0; i < 32; i++) begin
            if (bit_v > a) begin
                bit_v = bit_v >> 2;
            end
        end
        for (i = 0; i < 32; i++) begin
            if (bit_v != 64'd0) begin
                if (a >= r + bit_v) begin
                    a = a - (r + bit_v);
                    r = (r >> 1) + bit_v;
                end else begin
                    r = r >> 1;
                end
                bit_v = bit_v >> 2;
            end
        end
        return r;
    endfunction

    // 2^(-2^-idx) in Q.32, each a truncated square root of the previous one
    function automatic logic [31:0] gcb_root(input int idx);
        logic [63:0] s;
        int j;
        s = gcb_isqrt(64'd1 << 63);
        for (j = 1; j < 32; j++) begin
            if (j < idx) begin
                s = gcb_isqrt(s << 32);
            end
        end
        return s[31:0];
    endfunction

endpackage

`default_nettype wire

>>> rtl/gcb_log_rom.sv
// log2 distance table: per channel value, (log2 FS - log2 v) split by 100, registered read
`default_nettype none

module gcb_log_rom
    import gcb_pkg::*;
#(
    parameter int CHANNEL_BITS = 8
) (
    input  wire                     i_clk,
    input  wire                     i_en,
    input  wire  [CHANNEL_BITS-1:0] i_addr,
    output logic [A_BITS-1:0]       o_a,
    output logic [B_BITS-1:0]       o_b
);

    localparam int DEPTH = 1 << CHANNEL_BITS;
    localparam logic [63:0] FS = (64'd1 << CHANNEL_BITS) - 64'd1;

    logic [A_BITS+B_BITS-1:0] w_rom [DEPTH];

    for (genvar g = 0; g < DEPTH; g++) begin : g_entry
        localparam logic [63:0] D = (g == 0) ? 64'd0 :
            gcb_log2_q32(FS) - gcb_log2_q32(64'(g));
        localparam logic [63:0] A_V = D / 100;
        localparam logic [63:0] B_V = D % 100;
        assign w_rom[g] = {A_V[A_BITS-1:0], B_V[B_BITS-1:0]};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            {o_a, o_b} <= w_rom[i_addr];
        end
    end

endmodule

`default_nettype wire

>>> rtl/gcb_exp_stage.sv
// one step of the 2^(-f) product: multiply by a fixed root when its exponent bit is set
`default_nettype none

module gcb_exp_stage
    import gcb_pkg::*;
#(
    parameter int IDX = 1
) (
    input  wire        i_clk,
    input  wire        i_en,
    input  wire t_exp_data i_d,
    output t_exp_data  o_d
);

    localparam logic [31:0] ROOT = gcb_root(IDX);

    logic [ONE_BITS+31:0] w_prod;

    assign w_prod = (ONE_BITS + 32)'(i_d.r) * (ONE_BITS + 32)'(ROOT);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_d.e    <= i_d.e;
            o_d.zero <= i_d.zero;
            // fraction bit weight 2^-IDX sits at position 32 - IDX
            if (i_d.e[32-IDX]) begin
                o_d.r <= w_prod[ONE_BITS+31:32];
            end else begin
                o_d.r <= i_d.r;
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/gcb_channel.sv
// one color channel: log table, gamma scale, exp2 product chain, contrast/brightness and rounding
`default_nettype none

module gcb_channel
    import gcb_pkg::*;
#(
    parameter int CHANNEL_BITS = 8
) (
    input  wire                     i_clk,
    input  wire                     i_en,
    input  wire  t_gcb_cfg          i_cfg,
    input  wire  [CHANNEL_BITS-1:0] i_pix,
    output logic [CHANNEL_BITS-1:0] o_pix
);

    localparam int CB     = CHANNEL_BITS;
    localparam int W_BITS = CB + 11;
    localparam int N_BITS = CB + 10;
    localparam int R_BITS = N_BITS + 1;
    localparam int P_BITS = N_BITS + R_BITS;
    localparam int Q_BITS = P_BITS - N_BITS - 7;
    localparam logic [CB-1:0] FS_V = '1;
    localparam logic [R_BITS-1:0] RECIP =
        R_BITS'(((64'd1 << (N_BITS + 7)) + 64'd99) / 64'd100);

    // stage 1: table read
    logic [A_BITS-1:0]  w_a;
    logic [B_BITS-1:0]  w_b;
    logic               r_zero1;
    // stage 2..4: exponent e = a * g + round((b * g) / 100)
    logic [E_BITS-1:0]  r_p2;
    logic [T_BITS-1:0]  r_t2;
    logic               r_zero2;
    logic [E_BITS-1:0]  r_p3;
    logic [8:0]         r_qs3;
    logic               r_zero3;
    logic [E_BITS-1:0]  r_e4;
    logic               r_zero4;
    logic [TQ_BITS-1:0] w_tq;
    // exponent product chain
    t_exp_data          w_exp [33];
    // back end
    logic [ONE_BITS-1:0]       r_y;
    logic [ONE_BITS+7:0]       w_cy;
    logic [39:0]               r_cy;
    logic signed [9:0]         r_zh;
    logic [31:0]               r_zl;
    logic signed [W_BITS-1:0]  w_m1;
    logic [CB+31:0]            w_m2;
    logic signed [W_BITS-1:0]  r_m1;
    logic [CB-1:0]             r_m2;
    logic signed [W_BITS-1:0]  r_w;
    logic [P_BITS-1:0]         r_qp;
    logic                      r_neg;
    logic [Q_BITS-1:0]         w_q;

    gcb_log_rom #(
        .CHANNEL_BITS(CB)
    ) u_rom (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_addr(i_pix),
        .o_a   (w_a),
        .o_b   (w_b)
    );

    assign w_tq = TQ_BITS'(r_t2) * TQ_BITS'(DIV100_M);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_zero1 <= (i_pix == '0);
            r_p2    <= E_BITS'(w_a) * E_BITS'(i_cfg.gamma_exp);
            r_t2    <= T_BITS'(w_b) * T_BITS'(i_cfg.gamma_exp) + T_BITS'(50);
            r_zero2 <= r_zero1;
            r_p3    <= r_p2;
            r_qs3   <= w_tq[DIV100_SHIFT+8:DIV100_SHIFT];
            r_zero3 <= r_zero2;
            r_e4    <= r_p3 + E_BITS'(r_qs3);
            r_zero4 <= r_zero3;
        end
    end

    assign w_exp[0].r    = {1'b1, 32'd0};
    assign w_exp[0].e    = r_e4;
    assign w_exp[0].zero = r_zero4;

    for (genvar i = 1; i <= 32; i++) begin : g_exp
        gcb_exp_stage #(
            .IDX(i)
        ) u_stage (
            .i_clk(i_clk),
            .i_en (i_en),
            .i_d  (w_exp[i-1]),
            .o_d  (w_exp[i])
        );
    end

    assign w_cy = (ONE_BITS + 8)'(i_cfg.contrast) * (ONE_BITS + 8)'(r_y);
    assign w_m1 = W_BITS'($signed({1'b0, FS_V})) * W_BITS'(r_zh);
    assign w_m2 = (CB + 32)'(FS_V) * (CB + 32)'(r_zl);
    assign w_q  = r_qp[P_BITS-1:N_BITS+7];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_cfg.gamma_exp == '0) begin
                r_y <= {1'b1, 32'd0};
            end else if (w_exp[32].zero) begin
                r_y <= '0;
            end else begin
                r_y <= w_exp[32].r >> w_exp[32].e[E_BITS-1:32];
            end
            r_cy  <= w_cy[39:0];
            r_zh  <= $signed({2'b00, r_cy[39:32]}) + $signed({2'b00, i_cfg.brightness})
                     - 10'sd100;
            r_zl  <= r_cy[31:0];
            r_m1  <= w_m1;
            r_m2  <= w_m2[CB+31:32];
            // floor of the sum over 2^32, with half of the divisor added for rounding
            r_w   <= r_m1 + $signed({11'b0, r_m2}) + $signed(W_BITS'(50));
            r_neg <= r_w[W_BITS-1];
            r_qp  <= P_BITS'(r_w[N_BITS-1:0]) * P_BITS'(RECIP);
            if (r_neg) begin
                o_pix <= '0;
            end else if (w_q > Q_BITS'(FS_V)) begin
                o_pix <= FS_V;
            end else begin
                o_pix <= w_q[CB-1:0];
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/gamma_contrast_brightness_pixel.sv
// Gamma, contrast and brightness adjustment of RGB pixels on a stream interface.
// Each channel v becomes round(FS * (C * (v/FS)^G + B)) clamped to 0..FS, with
// FS = 2^CHANNEL_BITS - 1, C = contrast/100, G = gamma_exp/100 and
// B = (brightness - 100)/100. One pixel is accepted every clock while the output
// is not stalled; the chain of 32 multiply stages that builds 2^(-G*log2 distance)
// bit by bit of the exponent fraction makes up most of the pipe. A stall on the
// output freezes the whole pipe. Each channel holds a 2^CHANNEL_BITS entry log2 table
// built at elaboration. Registers are written through the config channel, which is
// always ready, and should only change while no pixel is in flight.
`default_nettype none

module gamma_contrast_brightness_pixel
    import gcb_pkg::*;
#(
    parameter int CHANNEL_BITS = 8
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    // stream input
    input  wire                  i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    // tdata: red_in, green_in, blue_in, zero fill
    input  wire  [((3*CHANNEL_BITS+7)/8)*8-1:0] i_s_axis_tdata,
    // stream output
    output logic                 o_m_axis_tvalid,
    input  wire                  i_m_axis_tready,
    // tdata: red_out, green_out, blue_out, zero fill
    output logic [((3*CHANNEL_BITS+7)/8)*8-1:0] o_m_axis_tdata,
    // configuration writes
    input  wire                  i_cfg_valid,
    output logic                 o_cfg_ready,
    input  wire  [1:0]           i_cfg_index,
    input  wire  [CFG_BITS-1:0]  i_cfg_data
);

    localparam int CB      = CHANNEL_BITS;
    localparam int TDATA_W = ((3 * CB + 7) / 8) * 8;

    t_gcb_cfg              r_cfg;
    logic [PIPE_DEPTH-1:0] r_vld;
    logic                  w_en;
    logic [CB-1:0]         w_pix_out [3];

    assign w_en            = !r_vld[PIPE_DEPTH-1] || i_m_axis_tready;
    assign o_s_axis_tready = w_en;
    assign o_m_axis_tvalid = r_vld[PIPE_DEPTH-1];
    assign o_cfg_ready     = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.contrast   <= CFG_BITS'(100);
            r_cfg.gamma_exp  <= CFG_BITS'(100);
            r_cfg.brightness <= CFG_BITS'(100);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_CONTRAST:   r_cfg.contrast   <= i_cfg_data;
                CFG_GAMMA_EXP:  r_cfg.gamma_exp  <= i_cfg_data;
                CFG_BRIGHTNESS: r_cfg.brightness <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[PIPE_DEPTH-2:0], i_s_axis_tvalid};
        end
    end

    for (genvar c = 0; c < 3; c++) begin : g_chan
        gcb_channel #(
            .CHANNEL_BITS(CB)
        ) u_chan (
            .i_clk(i_clk),
            .i_en (w_en),
            .i_cfg(r_cfg),
            .i_pix(i_s_axis_tdata[c*CB +: CB]),
            .o_pix(w_pix_out[c])
        );
    end

    assign o_m_axis_tdata = TDATA_W'({w_pix_out[2], w_pix_out[1], w_pix_out[0]});

`ifndef SYNTHESIS
    a_rst_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid right after reset");

    a_stall_freezes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(r_vld))
        else $error("pipeline valid bits moved during a stall");

    a_last_stage_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_en && r_vld[PIPE_DEPTH-2]) |=> o_m_axis_tvalid)
        else $error("transaction lost before the output register");

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> r_vld[0])
        else $error("accepted transaction did not enter the pipeline");
`endif

endmodule

`default_nettype wire
